// ===== rtl/tcie_pkg.sv =====
package tcie_pkg;

    localparam int unsigned WordW = 16;
    localparam int unsigned ImmW  = 6;
    localparam int unsigned RegIdxW = 3;
    localparam int unsigned NumRegs = 8;

    typedef logic [3:0] opcode_t;

    localparam opcode_t OP_NOP  = 4'd0;
    localparam opcode_t OP_MOV  = 4'd1;
    localparam opcode_t OP_ADD  = 4'd2;
    localparam opcode_t OP_SUB  = 4'd3;
    localparam opcode_t OP_JMP  = 4'd8;
    localparam opcode_t OP_JZ   = 4'd9;
    localparam opcode_t OP_HALT = 4'd12;

    typedef struct packed {
        logic ovf;
        logic carry;
        logic neg;
        logic zero;
    } flags_t;

    // everything the execute logic decides for one instruction
    typedef struct packed {
        logic                      wr;
        logic [WordW-1:0]          wval;
        flags_t                    flags;
        logic [WordW-1:0]          next_ip;
        logic                      running;
    } exec_res_t;

endpackage

// ===== rtl/toy_cpu_instruction_execute.sv =====
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, instruction_word      | into block
// out     | out_valid, out_stall, inst_address ...     | out of block
//
// one transaction per cycle sustained: an instruction waits in the
// input register, is executed in a single pass (register file read, alu,
// state update) and lands in the result register on the next edge
// reset clears registers, pointer and flags, and sets the running flag
// a stall on the result side holds the result register; the input register
// keeps taking a transaction as long as the result can move on
module toy_cpu_instruction_execute (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [15:0]                           instruction_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           inst_address,
    output logic [15:0]                           next_address,
    output logic                                  halted,
    output logic                                  reg_write,
    output logic [2:0]                            reg_index,
    output logic [15:0]                           reg_value,
    output logic                                  zero_flag,
    output logic                                  negative_flag,
    output logic                                  carry_flag,
    output logic                                  overflow_flag
);

    // input register
    logic                         ivalid_reg;
    logic                         ivalid_next;
    logic [15:0]                  instr_reg;

    // architectural state
    logic [15:0]                  ip_reg;
    tcie_pkg::flags_t             flags_reg;
    logic                         run_reg;

    // result register
    logic                         ovalid_reg;
    logic                         ovalid_next;
    logic [15:0]                  inst_addr_reg;
    logic [15:0]                  next_addr_reg;
    logic                         halted_reg;
    logic                         wr_reg;
    logic [2:0]                   idx_reg;
    logic [15:0]                  val_reg;
    tcie_pkg::flags_t             oflags_reg;

    logic                         accept;
    logic                         fire;
    tcie_pkg::opcode_t            op;
    logic [2:0]                   dst;
    logic [5:0]                   imm;
    logic [15:0]                  src;
    tcie_pkg::exec_res_t          res;

    // execute when an instruction waits and the result slot frees up
    assign fire     = ivalid_reg && (!ovalid_reg || !out_stall);
    assign in_stall = ivalid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign op  = tcie_pkg::opcode_t'(instr_reg[15:12]);
    assign dst = instr_reg[11:9];
    assign imm = instr_reg[5:0];

    tcie_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire && res.wr),
        .wr_idx  (dst),
        .wr_data (res.wval),
        .rd_idx  (dst),
        .rd_data (src)
    );

    tcie_alu u_alu (
        .op      (op),
        .imm     (imm),
        .src     (src),
        .ip      (ip_reg),
        .flags   (flags_reg),
        .running (run_reg),
        .res     (res)
    );

    always_comb
    begin
        ivalid_next = ivalid_reg;
        if (accept)
        begin
            ivalid_next = 1'b1;
        end
        else if (fire)
        begin
            ivalid_next = 1'b0;
        end

        ovalid_next = ovalid_reg;
        if (fire)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            ip_reg     <= '0;
            flags_reg  <= '0;
            run_reg    <= 1'b1;
        end
        else
        begin
            ivalid_reg <= ivalid_next;
            ovalid_reg <= ovalid_next;
            if (fire)
            begin
                ip_reg    <= res.next_ip;
                flags_reg <= res.flags;
                run_reg   <= res.running;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instruction_word;
        end
        if (fire)
        begin
            inst_addr_reg <= ip_reg;
            next_addr_reg <= res.next_ip;
            halted_reg    <= !res.running;
            wr_reg        <= res.wr;
            idx_reg       <= res.wr ? dst : 3'd0;
            val_reg       <= res.wval;
            oflags_reg    <= res.flags;
        end
    end

    assign out_valid     = ovalid_reg;
    assign inst_address  = inst_addr_reg;
    assign next_address  = next_addr_reg;
    assign halted        = halted_reg;
    assign reg_write     = wr_reg;
    assign reg_index     = idx_reg;
    assign reg_value     = val_reg;
    assign zero_flag     = oflags_reg.zero;
    assign negative_flag = oflags_reg.neg;
    assign carry_flag    = oflags_reg.carry;
    assign overflow_flag = oflags_reg.ovf;

endmodule

// ===== rtl/tcie_regfile.sv =====
module tcie_regfile (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tcie_pkg::RegIdxW-1:0]      wr_idx,
    input  logic [tcie_pkg::WordW-1:0]        wr_data,
    input  logic [tcie_pkg::RegIdxW-1:0]      rd_idx,
    output logic [tcie_pkg::WordW-1:0]        rd_data
);

    logic [tcie_pkg::WordW-1:0] regs_reg [tcie_pkg::NumRegs];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcie_pkg::NumRegs; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            regs_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = regs_reg[rd_idx];

endmodule

// ===== rtl/tcie_alu.sv =====
module tcie_alu (
    input  tcie_pkg::opcode_t                 op,
    input  logic [tcie_pkg::ImmW-1:0]         imm,
    input  logic [tcie_pkg::WordW-1:0]        src,
    input  logic [tcie_pkg::WordW-1:0]        ip,
    input  tcie_pkg::flags_t                  flags,
    input  logic                              running,
    output tcie_pkg::exec_res_t               res
);

    logic [tcie_pkg::WordW-1:0] imm_ext;
    logic [tcie_pkg::WordW:0]   add_sum;
    logic [tcie_pkg::WordW-1:0] sub_diff;
    logic                       add_ovf;
    logic                       sub_ovf;
    logic                       sub_lt;

    assign imm_ext  = {{(tcie_pkg::WordW-tcie_pkg::ImmW){1'b0}}, imm};
    assign add_sum  = {1'b0, src} + {1'b0, imm_ext};
    assign sub_diff = src - imm_ext;
    assign add_ovf  = ~(src[tcie_pkg::WordW-1] ^ imm_ext[tcie_pkg::WordW-1])
                    & (src[tcie_pkg::WordW-1] ^ add_sum[tcie_pkg::WordW-1]);
    assign sub_ovf  = (src[tcie_pkg::WordW-1] ^ imm_ext[tcie_pkg::WordW-1])
                    & (src[tcie_pkg::WordW-1] ^ sub_diff[tcie_pkg::WordW-1]);
    assign sub_lt   = $signed(src) < $signed(imm_ext);

    always_comb
    begin
        res         = '0;
        res.flags   = flags;
        res.next_ip = ip;
        res.running = running;
        if (running)
        begin
            res.next_ip = ip + 16'd1;
            case (op)
                tcie_pkg::OP_MOV:
                begin
                    res.wr   = 1'b1;
                    res.wval = imm_ext;
                end
                tcie_pkg::OP_ADD:
                begin
                    res.wr          = 1'b1;
                    res.wval        = add_sum[tcie_pkg::WordW-1:0];
                    res.flags.zero  = (add_sum[tcie_pkg::WordW-1:0] == '0);
                    res.flags.neg   = add_sum[tcie_pkg::WordW-1];
                    res.flags.carry = add_sum[tcie_pkg::WordW];
                    res.flags.ovf   = add_ovf;
                end
                tcie_pkg::OP_SUB:
                begin
                    res.wr          = 1'b1;
                    res.wval        = sub_diff;
                    res.flags.zero  = (sub_diff == '0);
                    res.flags.neg   = sub_diff[tcie_pkg::WordW-1];
                    res.flags.carry = sub_lt;
                    res.flags.ovf   = sub_ovf;
                end
                tcie_pkg::OP_JMP:
                begin
                    res.next_ip = imm_ext;
                end
                tcie_pkg::OP_JZ:
                begin
                    if (flags.zero)
                    begin
                        res.next_ip = imm_ext;
                    end
                end
                tcie_pkg::OP_HALT:
                begin
                    res.running = 1'b0;
                end
                default:
                begin
                    // nop and unimplemented opcodes
                end
            endcase
        end
    end

endmodule

// ===== rtl/tcie_checker.sv =====
module tcie_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] inst_address,
    input  logic [15:0] next_address,
    input  logic        halted,
    input  logic        reg_write,
    input  logic [2:0]  reg_index,
    input  logic [15:0] reg_value
);

    logic        seen_reg;
    logic        halt_seen_reg;
    logic [15:0] prev_next_reg;
    logic        out_take;

    assign out_take = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            halt_seen_reg <= 1'b0;
            prev_next_reg <= '0;
        end
        else if (out_take)
        begin
            seen_reg      <= 1'b1;
            halt_seen_reg <= halt_seen_reg || halted;
            prev_next_reg <= next_address;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_address) && $stable(reg_value))
        else $error("result changed under stall");

    // each transaction starts where the previous one said to continue
    a_ip_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> inst_address == prev_next_reg)
        else $error("instruction pointer chain broken");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halt_seen_reg |-> halted && inst_address == next_address)
        else $error("activity after halt");

    // a halted transaction writes nothing
    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !reg_write)
        else $error("register write while halted");

    // no write means empty write fields
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_write |-> reg_index == 3'd0 && reg_value == 16'd0)
        else $error("write fields set without a write");

endmodule

bind toy_cpu_instruction_execute tcie_checker u_tcie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inst_address (inst_address),
    .next_address (next_address),
    .halted       (halted),
    .reg_write    (reg_write),
    .reg_index    (reg_index),
    .reg_value    (reg_value)
);
